@@ hw/rtl/bas_pkg.sv @@
`timescale 1ns / 1ps

package bas_pkg;

	localparam int REG_W        = 11;
	localparam int SAMPLE_W     = 8;
	localparam int RESULT_W     = 16;
	localparam int SUM_W        = 12;  // nine samples of 8 bits
	localparam int CNT_W        = 4;   // 1..9 cells
	localparam int RECIP_W      = 24;
	localparam int PROD_W       = SUM_W + RECIP_W;
	// mean = floor(sum * 2^8 / cnt) = (sum * ceil(2^23 / cnt)) >> 15, exact for sum < 2^12
	localparam int FRAC_SHIFT   = 15;

	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;

	localparam logic [REG_W-1:0] ROWS_RESET = 11'd256;
	localparam logic [REG_W-1:0] COLS_RESET = 11'd256;

	typedef enum logic [0:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;  // take input beat, start line store read
		logic load;     // write line stores, shift window, step input position
		logic sum;      // register masked window sum and cell count
		logic mul;      // register reciprocal product
		logic emit;     // load output register, step output position
	} cmd_t;

	typedef struct packed {
		logic skip;      // flush beat inside the frame: dropped
		logic have;      // current item produces a result
		logic out_free;  // output register can take a new result
	} sts_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		r = '0;
		case (cnt)
			4'd1:    r = 24'd8388608;
			4'd2:    r = 24'd4194304;
			4'd3:    r = 24'd2796203;
			4'd4:    r = 24'd2097152;
			4'd5:    r = 24'd1677722;
			4'd6:    r = 24'd1398102;
			4'd7:    r = 24'd1198373;
			4'd8:    r = 24'd1048576;
			4'd9:    r = 24'd932068;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/bas_ram.sv @@
`timescale 1ns / 1ps

module bas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ hw/rtl/bas_ctrl.sv @@
`timescale 1ns / 1ps

module bas_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  bas_pkg::sts_t sts,
	output bas_pkg::cmd_t cmd
);

	bas_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			bas_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					if (!sts.skip) begin
						state_d = bas_pkg::ST_LOAD;
					end
				end
			end
			bas_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.have ? bas_pkg::ST_SUM : bas_pkg::ST_IDLE;
			end
			bas_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = bas_pkg::ST_MUL;
			end
			bas_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = bas_pkg::ST_EMIT;
			end
			bas_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = bas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bas_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_load_follows_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $past(cmd.capture))
		else $error("line store write without a preceding read");

	a_emit_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ($past(cmd.mul) || $past(state_q) == bas_pkg::ST_EMIT))
		else $error("result emitted without a product");
`endif

endmodule

@@ hw/rtl/bas_dp.sv @@
`timescale 1ns / 1ps

module bas_dp #(
	parameter int MAX_COLS = bas_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = bas_pkg::DEF_MAX_ROWS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bas_pkg::cmd_t                        cmd,
	output bas_pkg::sts_t                        sts,
	input  logic [bas_pkg::SAMPLE_W-1:0]         s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 cfg_valid,
	input  logic [0:0]                           cfg_index,
	input  logic [bas_pkg::REG_W-1:0]            cfg_data,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bas_pkg::RESULT_W-1:0]         m_tdata,
	output logic                                 m_tlast
);

	localparam int AW = $clog2(MAX_COLS);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 2);  // input row runs two rows past the frame

	localparam int SW = bas_pkg::SAMPLE_W;

	logic [bas_pkg::REG_W-1:0] rows_q, cols_q;
	logic [bas_pkg::REG_W-1:0] cfg_clamped;
	int                        cfg_limit;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;

	logic [SW-1:0] val_q;
	logic [SW-1:0] older_rd, newer_rd;
	logic [SW-1:0] win_q [3][3];

	logic [bas_pkg::SUM_W-1:0]  sum_q, sum_c;
	logic [bas_pkg::CNT_W-1:0]  cnt_q, cnt_c;
	logic [bas_pkg::PROD_W-1:0] prod_q;

	logic                           out_valid_q, out_last_q;
	logic [bas_pkg::RESULT_W-1:0]   out_data_q;

	logic in_frame, in_last_col, out_last;
	logic up_ok, down_ok, left_ok, right_ok;
	logic [1:0] row_ok_cnt, col_ok_cnt;
	logic [2:0] row_ok, col_ok;

	// register writes: zero reads as one, above the limit reads as the limit
	always_comb begin
		cfg_limit = (cfg_index == bas_pkg::REG_ROWS) ? MAX_ROWS : MAX_COLS;
		if (cfg_data == '0) begin
			cfg_clamped = bas_pkg::REG_W'(1);
		end else if (32'(cfg_data) > cfg_limit) begin
			cfg_clamped = bas_pkg::REG_W'(cfg_limit);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= bas_pkg::ROWS_RESET;
			cols_q <= bas_pkg::COLS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bas_pkg::REG_ROWS: rows_q <= cfg_clamped;
				bas_pkg::REG_COLS: cols_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// positions
	assign in_frame    = 32'(in_row_q) < 32'(rows_q);
	assign in_last_col = 32'(in_col_q) == 32'(cols_q) - 1;
	assign out_last    = (32'(out_row_q) == 32'(rows_q) - 1) &&
	                     (32'(out_col_q) == 32'(cols_q) - 1);

	assign sts.skip     = s_tuser && in_frame;
	assign sts.have     = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_valid) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (cmd.load) begin
				if (in_last_col) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				if (out_last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (32'(out_col_q) == 32'(cols_q) - 1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// line stores: read on capture, write back on load, same column address
	bas_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_older (
		.clk   (clk),
		.we    (cmd.load),
		.re    (cmd.capture),
		.addr  (in_col_q[AW-1:0]),
		.wdata (newer_rd),
		.rdata (older_rd)
	);

	bas_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_newer (
		.clk   (clk),
		.we    (cmd.load),
		.re    (cmd.capture),
		.addr  (in_col_q[AW-1:0]),
		.wdata (val_q),
		.rdata (newer_rd)
	);

	// samples past the frame enter as zero
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_q <= in_frame ? s_tdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= older_rd;
			win_q[1][2] <= newer_rd;
			win_q[2][2] <= val_q;
		end
	end

	// after the shift the center column is column 1 for every output,
	// including the last column of a row; border cells are masked
	assign up_ok    = out_row_q != '0;
	assign down_ok  = 32'(out_row_q) + 1 < 32'(rows_q);
	assign left_ok  = out_col_q != '0;
	assign right_ok = 32'(out_col_q) + 1 < 32'(cols_q);
	assign row_ok   = {down_ok, 1'b1, up_ok};
	assign col_ok   = {right_ok, 1'b1, left_ok};
	assign row_ok_cnt = 2'd1 + 2'(up_ok) + 2'(down_ok);
	assign col_ok_cnt = 2'd1 + 2'(left_ok) + 2'(right_ok);

	always_comb begin
		sum_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_c = sum_c + bas_pkg::SUM_W'(win_q[r][c]);
				end
			end
		end
		cnt_c = bas_pkg::CNT_W'(row_ok_cnt) * bas_pkg::CNT_W'(col_ok_cnt);
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_q <= sum_c;
			cnt_q <= cnt_c;
		end
		if (cmd.mul) begin
			prod_q <= bas_pkg::PROD_W'(sum_q) * bas_pkg::PROD_W'(bas_pkg::recip(cnt_q));
		end
		if (cmd.emit) begin
			out_data_q <= prod_q[bas_pkg::FRAC_SHIFT +: bas_pkg::RESULT_W];
			out_last_q <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum |=> (cnt_q != '0))
		else $error("empty neighborhood for an emitted cell");
`endif

endmodule

@@ hw/rtl/border_aware_box_smoother.sv @@
`timescale 1ns / 1ps

// A beat passes the line store read, window load, sum, multiply and emit steps; emit
// waits while the output register is held. A new beat is taken only once the last is
// through: a beat with no result ends after load, a dropped flush beat after read.
// Reset (arst_n low, async): grid 256 x 256, window zero, frame position zero, no result held.
// Line stores are not cleared; border cells never use unwritten entries.
module border_aware_box_smoother #(
	parameter int MAX_COLS = bas_pkg::DEF_MAX_COLS,  // 4..8192, sets line store depth
	parameter int MAX_ROWS = bas_pkg::DEF_MAX_ROWS   // 1..65536, sets row counter width
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bas_pkg::SAMPLE_W-1:0]      s_tdata,   // [7:0] height_sample
	input  logic                              s_tuser,   // [0] kind: 1 = flush tick

	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bas_pkg::RESULT_W-1:0]      m_tdata,   // [15:0] smoothed_height, 8 frac bits
	output logic                              m_tlast,   // frame_last

	// register writes: index 0 = grid_rows, 1 = grid_cols
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [0:0]                        cfg_index,
	input  logic [bas_pkg::REG_W-1:0]         cfg_data
);

	bas_pkg::cmd_t cmd;
	bas_pkg::sts_t sts;

	// a register write restarts the frame; it is taken at any cycle
	assign cfg_ready = 1'b1;

	// controller: one beat at a time through read, load, sum, multiply, emit
	bas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: grid registers, positions, line stores, 3x3 window,
	// masked sum and reciprocal multiply for the border-aware mean
	bas_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
